// ===== design/fmva_pkg.sv =====
// ----------------------------------------------------------------------------
// fmva_pkg
// Shared types, constants and the note frequency ROM for the FM voice
// allocator / key-on writer.
// ----------------------------------------------------------------------------
package fmva_pkg;

  // Voice and synth constants
  localparam int NUM_CHANNELS    = 9;
  localparam int SYNTH_SAMPLE_HZ = 49716;
  localparam int CH_W            = 4;
  localparam logic [CH_W-1:0] RHYTHM_FIRST_CH = CH_W'(6);
  localparam logic [CH_W-1:0] RHYTHM_LAST_CH  = CH_W'(NUM_CHANNELS - 1);

  // Synth register bases
  localparam logic [7:0] REG_FREQ_LO = 8'hA0;
  localparam logic [7:0] REG_FREQ_HI = 8'hB0;
  localparam logic [7:0] REG_RHYTHM  = 8'hBD;

  // Frequency ROM: one {block[2:0], fnum[9:0]} entry per MIDI note
  localparam int NUM_NOTES     = 128;
  localparam int FREQ_ENTRY_W  = 13;
  localparam int FREQ_ROM_BITS = NUM_NOTES * FREQ_ENTRY_W;
  localparam logic [63:0] FREQ_DEN = 64'(SYNTH_SAMPLE_HZ) * 64'd1000000000000;

  // 2^(k/12) scaled by 10^12
  localparam logic [63:0] SEMITONE_RATIO [12] = '{
    64'd1000000000000, 64'd1059463094359, 64'd1122462048309, 64'd1189207115003,
    64'd1259921049895, 64'd1334839854170, 64'd1414213562373, 64'd1498307076877,
    64'd1587401051968, 64'd1681792830507, 64'd1781797436281, 64'd1887748625363
  };

  // Result kinds
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_PATCH = 2'd1,
    KIND_DROP  = 2'd2
  } kind_t;

  // Configuration register indexes
  localparam logic CFG_RHYTHM_ENABLE = 1'b0;

  typedef struct packed {
    logic [6:0] note;
    logic [6:0] velocity;
    logic [7:0] instrument_id;
    logic       carrier_enabled;
    logic       rhythm_on;
    logic [3:0] rhythm_type;
    logic       am_depth;
    logic       vib_depth;
  } in_item_t;

  typedef struct packed {
    kind_t           kind;
    logic [CH_W-1:0] channel;
    logic [7:0]      reg_addr;
    logic [7:0]      reg_data;
    logic            last;
  } out_item_t;

  // floor(num * 2^sh / FREQ_DEN), long division one bit a step
  function automatic logic [63:0] scaled_div(input logic [63:0] num, input int sh);
    logic [63:0] q;
    logic [63:0] r;
    q = num / FREQ_DEN;
    r = num % FREQ_DEN;
    for (int i = 0; i < sh; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= FREQ_DEN) begin
        q = q + 64'd1;
        r = r - FREQ_DEN;
      end
    end
    return q;
  endfunction

  // Built at elaboration: smallest block giving fnum below 1024, else zero
  function automatic logic [FREQ_ROM_BITS-1:0] build_freq_rom();
    logic [FREQ_ROM_BITS-1:0] rom;
    logic [63:0]              num;
    logic [63:0]              f;
    logic                     done;
    int                       m;
    int                       oct;
    int                       blk;
    rom = '0;
    for (int n = 0; n < NUM_NOTES; n++) begin
      m    = n + 3;
      oct  = m / 12 - 6;
      num  = 64'd440 * SEMITONE_RATIO[m % 12];
      done = 1'b0;
      for (int b = 0; b < 8; b++) begin
        if (!done) begin
          f = scaled_div(num, 20 + oct - b);
          if (f < 64'd1024) begin
            done = 1'b1;
            blk  = b;
            rom[n*FREQ_ENTRY_W +: FREQ_ENTRY_W] = {3'(blk), f[9:0]};
          end
        end
      end
    end
    return rom;
  endfunction

  localparam logic [FREQ_ROM_BITS-1:0] FREQ_ROM = build_freq_rom();

endpackage

// ===== design/fm_voice_allocator_keyon_writer_unit.sv =====
// ----------------------------------------------------------------------------
// fm_voice_allocator_keyon_writer_unit
// Turns note events into FM synth register writes: first-free voice
// allocation, note-off release and rhythm-mode percussion writes, driven by
// a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in_      input      in_valid / in_stall     in_data  (in_item_t)
// out_     output     out_valid / out_stall   out_data (out_item_t)
// cfg      config     psel/penable/pwrite     paddr[2:0], pwdata/prdata 32b
//
// One event at a time: an accept step, a dispatch step (channel search),
// then one result item per cycle while the output does not stall; the
// microprogram step counter walks through the items.
// A new event is accepted while the last result of the previous one waits
// in the output register. Output stall freezes the sequencer on its
// current emitting step. Reset (rst_n, synchronous) frees all channels and
// clears rhythm_enable; the frequency ROM is constant.
// ----------------------------------------------------------------------------
module fm_voice_allocator_keyon_writer_unit
  import fmva_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // event input
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Microprogram steps
  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH,
    ST_R_OFF_LO, ST_R_OFF_HI, ST_BD,
    ST_R_ON_PATCH, ST_R_ON_LO, ST_R_ON_HI,
    ST_DROP,
    ST_M_ON_PATCH, ST_M_ON_LO, ST_M_ON_HI,
    ST_M_OFF_LO, ST_M_OFF_HI
  } upc_t;

  typedef enum logic [2:0] {OP_NONE, OP_PATCH, OP_FLO, OP_FHI, OP_BD, OP_DROP} op_t;
  typedef enum logic [2:0] {SEQ_WAIT, SEQ_DISPATCH, SEQ_NEXT, SEQ_LOOP, SEQ_END} seq_t;
  typedef enum logic [1:0] {UPD_NONE, UPD_ALLOC, UPD_FREE, UPD_RINST} upd_t;

  typedef struct packed {
    op_t  op;
    upd_t upd;
    logic ch_rhythm;   // channel from rhythm counter, else found channel
    logic note_zero;   // frequency of note 0
    logic key_carrier; // key bit from carrier_enabled, else clear
    logic last;
    seq_t seq;
    upc_t target;
    upc_t alt;
  } ctrl_t;

  // Control store
  function automatic ctrl_t ucode(input upc_t pc);
    ctrl_t w;
    w = '0;
    case (pc)
      ST_IDLE:     w.seq = SEQ_WAIT;
      ST_DISPATCH: w.seq = SEQ_DISPATCH;
      ST_R_OFF_LO: begin
        w.op = OP_FLO; w.ch_rhythm = 1'b1; w.note_zero = 1'b1; w.seq = SEQ_NEXT;
      end
      ST_R_OFF_HI: begin
        w.op = OP_FHI; w.ch_rhythm = 1'b1; w.note_zero = 1'b1; w.seq = SEQ_LOOP;
        w.target = ST_R_OFF_LO; w.alt = ST_BD;
      end
      ST_BD: begin
        w.op = OP_BD; w.last = 1'b1; w.seq = SEQ_END;
      end
      ST_R_ON_PATCH: begin
        w.op = OP_PATCH; w.upd = UPD_RINST; w.ch_rhythm = 1'b1; w.seq = SEQ_NEXT;
      end
      ST_R_ON_LO: begin
        w.op = OP_FLO; w.ch_rhythm = 1'b1; w.seq = SEQ_NEXT;
      end
      ST_R_ON_HI: begin
        w.op = OP_FHI; w.ch_rhythm = 1'b1; w.seq = SEQ_LOOP;
        w.target = ST_R_ON_PATCH; w.alt = ST_BD;
      end
      ST_DROP: begin
        w.op = OP_DROP; w.last = 1'b1; w.seq = SEQ_END;
      end
      ST_M_ON_PATCH: begin
        w.op = OP_PATCH; w.upd = UPD_ALLOC; w.seq = SEQ_NEXT;
      end
      ST_M_ON_LO: begin
        w.op = OP_FLO; w.seq = SEQ_NEXT;
      end
      ST_M_ON_HI: begin
        w.op = OP_FHI; w.key_carrier = 1'b1; w.last = 1'b1; w.seq = SEQ_END;
      end
      ST_M_OFF_LO: begin
        w.op = OP_FLO; w.upd = UPD_FREE; w.seq = SEQ_NEXT;
      end
      ST_M_OFF_HI: begin
        w.op = OP_FHI; w.last = 1'b1; w.seq = SEQ_END;
      end
      default:     w.seq = SEQ_END;
    endcase
    return w;
  endfunction

  // Sequencer and output registers
  upc_t            upc_r, upc_nxt;
  in_item_t        item_r;
  logic [CH_W-1:0] found_r;
  logic [CH_W-1:0] rch_r, rch_nxt;
  logic            out_valid_r;
  out_item_t       out_item_r, out_item_nxt;
  logic            rhythm_en_r;

  // Channel state
  logic            chan_free_r [NUM_CHANNELS];
  logic [6:0]      chan_note_r [NUM_CHANNELS];
  logic [7:0]      chan_inst_r [NUM_CHANNELS];

  ctrl_t           cw;
  logic            in_fire;
  logic            out_free;
  logic            emit;
  logic            step_go;
  logic            hit;
  logic [CH_W-1:0] hit_ch;
  logic            perc_sel;
  logic            vel_on;
  logic [CH_W-1:0] ch;
  logic [6:0]      note_idx;
  logic [FREQ_ENTRY_W-1:0] freq;
  logic            key;
  logic [4:0]      drum;
  logic            cfg_wr;

  assign cw       = ucode(upc_r);
  assign in_stall = (upc_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (cw.op != OP_NONE);
  assign step_go  = !emit || out_free;

  assign perc_sel = rhythm_en_r && item_r.rhythm_on;
  assign vel_on   = (item_r.velocity != 7'd0);

  // Channel search: lowest free channel, or lowest holding note and tag
  always_comb begin
    hit    = 1'b0;
    hit_ch = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (vel_on ? chan_free_r[i]
                 : (!chan_free_r[i] && chan_note_r[i] == item_r.note &&
                    chan_inst_r[i] == item_r.instrument_id)) begin
        hit    = 1'b1;
        hit_ch = CH_W'(i);
      end
    end
  end

  // Next step
  always_comb begin
    upc_nxt = upc_r;
    rch_nxt = rch_r;
    case (cw.seq)
      SEQ_WAIT: begin
        if (in_fire) begin
          upc_nxt = ST_DISPATCH;
          rch_nxt = RHYTHM_FIRST_CH;
        end
      end
      SEQ_DISPATCH: begin
        if (perc_sel)  upc_nxt = vel_on ? ST_R_ON_PATCH : ST_R_OFF_LO;
        else if (!hit) upc_nxt = ST_DROP;
        else           upc_nxt = vel_on ? ST_M_ON_PATCH : ST_M_OFF_LO;
      end
      SEQ_NEXT: begin
        if (step_go) upc_nxt = upc_t'(upc_r + 4'd1);
      end
      SEQ_LOOP: begin
        if (step_go) begin
          if (rch_r != RHYTHM_LAST_CH) begin
            upc_nxt = cw.target;
            rch_nxt = rch_r + CH_W'(1);
          end else begin
            upc_nxt = cw.alt;
          end
        end
      end
      SEQ_END: begin
        if (step_go) upc_nxt = ST_IDLE;
      end
      default: upc_nxt = ST_IDLE;
    endcase
  end

  // Result datapath
  assign ch       = cw.ch_rhythm ? rch_r : found_r;
  assign note_idx = cw.note_zero ? 7'd0 : item_r.note;
  assign freq     = FREQ_ROM[FREQ_ENTRY_W*note_idx +: FREQ_ENTRY_W];
  assign key      = cw.key_carrier && item_r.carrier_enabled;

  always_comb begin
    drum = '0;
    if (vel_on && item_r.rhythm_type inside {[4'd6:4'd10]}) begin
      drum = 5'd16 >> (item_r.rhythm_type - 4'd6);
    end
  end

  always_comb begin
    out_item_nxt      = '0;
    out_item_nxt.last = cw.last;
    case (cw.op)
      OP_PATCH: begin
        out_item_nxt.kind    = KIND_PATCH;
        out_item_nxt.channel = ch;
      end
      OP_FLO: begin
        out_item_nxt.kind     = KIND_WRITE;
        out_item_nxt.channel  = ch;
        out_item_nxt.reg_addr = REG_FREQ_LO + 8'(ch);
        out_item_nxt.reg_data = freq[7:0];
      end
      OP_FHI: begin
        out_item_nxt.kind     = KIND_WRITE;
        out_item_nxt.channel  = ch;
        out_item_nxt.reg_addr = REG_FREQ_HI + 8'(ch);
        out_item_nxt.reg_data = {2'b00, key, freq[12:10], freq[9:8]};
      end
      OP_BD: begin
        out_item_nxt.kind     = KIND_WRITE;
        out_item_nxt.reg_addr = REG_RHYTHM;
        out_item_nxt.reg_data = {item_r.am_depth, item_r.vib_depth, 1'b1, drum};
      end
      OP_DROP: out_item_nxt.kind = KIND_DROP;
      default: out_item_nxt.kind = KIND_WRITE;
    endcase
  end

  // Sequencer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= ST_IDLE;
      rch_r       <= RHYTHM_FIRST_CH;
      out_valid_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      rch_r <= rch_nxt;
      if (emit && out_free) begin
        out_valid_r <= 1'b1;
        out_item_r  <= out_item_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) item_r <= in_data;
      if (cw.seq == SEQ_DISPATCH) found_r <= hit_ch;
    end
  end

  // Channel table updates, on the step that carries them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_free_r[i] <= 1'b1;
        chan_inst_r[i] <= '0;
      end
    end else if (emit && out_free) begin
      case (cw.upd)
        UPD_ALLOC: begin
          chan_free_r[found_r] <= 1'b0;
          chan_note_r[found_r] <= item_r.note;
          chan_inst_r[found_r] <= item_r.instrument_id;
        end
        UPD_FREE: begin
          chan_free_r[found_r] <= 1'b1;
          chan_inst_r[found_r] <= '0;
        end
        UPD_RINST: chan_inst_r[rch_r] <= item_r.instrument_id;
        default: ;
      endcase
    end
  end

  // Configuration register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rhythm_en_r <= 1'b0;
    end else if (cfg_wr && paddr[2] == CFG_RHYTHM_ENABLE) begin
      rhythm_en_r <= pwdata[0];
    end
  end

  assign prdata    = (paddr[2] == CFG_RHYTHM_ENABLE) ? {31'd0, rhythm_en_r} : 32'd0;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Assertions
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> upc_r == ST_DISPATCH)
    else $error("accepted event did not reach dispatch");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    emit && out_free && cw.last |=> upc_r == ST_IDLE)
    else $error("sequencer continued after last item");

  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_DROP |-> out_data.last)
    else $error("dropped event item without last");

  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit && out_free && cw.upd == UPD_ALLOC |=> !chan_free_r[$past(found_r)])
    else $error("allocated channel still free");

  a_rch_range: assert property (@(posedge clk) disable iff (!rst_n)
    cw.ch_rhythm |-> rch_r >= RHYTHM_FIRST_CH && rch_r <= RHYTHM_LAST_CH)
    else $error("rhythm channel out of range");

endmodule

// ===== bench/fm_voice_write_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fm_voice_write_checker
// Watches the event, result and register ports of the voice allocator,
// keeps its own copy of the voice table and rhythm mode, works out the
// register writes each accepted event should give and compares every
// accepted result with the oldest one still owed.
// ----------------------------------------------------------------------------
module fm_voice_write_checker
  import fmva_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          backlog
);

  localparam logic [7:0] VOICE_FREE  = 8'h80;
  localparam logic [2:0] RHYTHM_ADDR = 3'(4 * int'(CFG_RHYTHM_ENABLE));
  localparam int         DRUM_LO     = 6;
  localparam int         DRUM_HI     = 10;

  logic        rhythm_en;
  logic [7:0]  voice_note [NUM_CHANNELS];
  logic [7:0]  voice_inst [NUM_CHANNELS];
  logic [12:0] pitch_rom  [NUM_NOTES];
  out_item_t   due_writes [$];

  // block/fnum for one note: exact floor of the scaled frequency, lowest
  // block whose fnum fits in ten bits, zero when none does
  function automatic logic [12:0] pitch_word(input int n);
    logic [127:0] scaled;
    logic [127:0] fnum;
    int           m;
    int           sh;
    m = n + 3;
    for (int b = 0; b < 8; b++) begin
      sh     = 20 + (m / 12 - 6) - b;
      scaled = (128'(440) * 128'(SEMITONE_RATIO[m % 12])) << sh;
      fnum   = scaled / (128'(SYNTH_SAMPLE_HZ) * 128'd1000000000000);
      if (fnum < 128'd1024) return {3'(b), fnum[9:0]};
    end
    return '0;
  endfunction

  initial begin
    for (int n = 0; n < NUM_NOTES; n++) pitch_rom[n] = pitch_word(n);
  end

  task automatic owe(input kind_t k, input int ch, input logic [7:0] addr,
                     input logic [7:0] data, input logic fin);
    out_item_t r;
    r.kind     = k;
    r.channel  = CH_W'(ch);
    r.reg_addr = addr;
    r.reg_data = data;
    r.last     = fin;
    due_writes.push_back(r);
  endtask

  // frequency-low then key/block/frequency-high
  task automatic owe_pitch(input int ch, input logic key, input logic [6:0] note,
                           input logic fin);
    logic [12:0] pw;
    pw = pitch_rom[note];
    owe(KIND_WRITE, ch, REG_FREQ_LO + 8'(ch), pw[7:0], 1'b0);
    owe(KIND_WRITE, ch, REG_FREQ_HI + 8'(ch), {2'b00, key, pw[12:10], pw[9:8]}, fin);
  endtask

  // expected writes for one event, updating the voice table as the block does
  task automatic plan_writes(input in_item_t ev);
    logic [7:0] drum;
    int         hit;
    hit = -1;
    if (rhythm_en && ev.rhythm_on) begin
      for (int c = int'(RHYTHM_FIRST_CH); c < NUM_CHANNELS; c++) begin
        if (ev.velocity != 0) begin
          voice_inst[c] = ev.instrument_id;
          owe(KIND_PATCH, c, 8'h00, 8'h00, 1'b0);
          owe_pitch(c, 1'b0, ev.note, 1'b0);
        end else begin
          owe_pitch(c, 1'b0, 7'd0, 1'b0);
        end
      end
      drum = 8'h00;
      if (ev.velocity != 0 && ev.rhythm_type >= DRUM_LO && ev.rhythm_type <= DRUM_HI)
        drum = 8'h01 << (DRUM_HI - int'(ev.rhythm_type));
      owe(KIND_WRITE, 0, REG_RHYTHM,
          {ev.am_depth, ev.vib_depth, 1'b1, drum[4:0]}, 1'b1);
    end else begin
      // lowest free voice for a note-on, lowest holder for a note-off
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (hit < 0) begin
          if (ev.velocity != 0) begin
            if (voice_note[c][7]) hit = c;
          end else if (voice_note[c] == {1'b0, ev.note} &&
                       voice_inst[c] == ev.instrument_id) begin
            hit = c;
          end
        end
      end
      if (hit < 0) begin
        owe(KIND_DROP, 0, 8'h00, 8'h00, 1'b1);
      end else if (ev.velocity != 0) begin
        voice_note[hit] = {1'b0, ev.note};
        voice_inst[hit] = ev.instrument_id;
        owe(KIND_PATCH, hit, 8'h00, 8'h00, 1'b0);
        owe_pitch(hit, ev.carrier_enabled, ev.note, 1'b1);
      end else begin
        voice_note[hit] = VOICE_FREE;
        voice_inst[hit] = 8'h00;
        owe_pitch(hit, 1'b0, ev.note, 1'b1);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      rhythm_en  = 1'b0;
      fail_count = 0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        voice_note[c] = VOICE_FREE;
        voice_inst[c] = 8'h00;
      end
      due_writes.delete();
    end else begin
      // results first: anything leaving now belongs to an earlier event
      if (out_valid && !out_stall) begin
        if (due_writes.size() == 0) begin
          $error("unexpected result: kind %0d channel %0d addr %h data %h last %0d",
                 out_data.kind, out_data.channel, out_data.reg_addr,
                 out_data.reg_data, out_data.last);
          fail_count++;
        end else begin
          want = due_writes.pop_front();
          check_field("kind", 8'(want.kind), 8'(out_data.kind));
          check_field("channel", 8'(want.channel), 8'(out_data.channel));
          check_field("reg_addr", want.reg_addr, out_data.reg_addr);
          check_field("reg_data", want.reg_data, out_data.reg_data);
          check_field("last", 8'(want.last), 8'(out_data.last));
        end
      end
      if (in_valid && !in_stall) plan_writes(in_data);
      if (psel && penable && pwrite && pready && paddr == RHYTHM_ADDR)
        rhythm_en = pwdata[0];
    end
    backlog <= due_writes.size();
  end

endmodule

// ===== bench/fm_voice_allocator_keyon_writer_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fm_voice_allocator_keyon_writer_unit_test
// Drives note events and rhythm mode writes into the voice allocator:
// a directed pass over voice exhaustion, release, drops and every drum kind,
// then well-formed note-on/note-off traffic with some noise under three
// idling patterns. The checker alongside predicts and compares the writes.
// ----------------------------------------------------------------------------
module fm_voice_allocator_keyon_writer_unit_test;
  import fmva_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int CHUNKS      = 4;
  localparam int CHUNK_ITEMS = 38;
  localparam int TAIL_CYCLES = 20;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  int          cycle_count    = 0;
  int          fail_count;
  int          backlog;
  logic [14:0] held_q [$];   // {instrument, note} of notes believed sounding

  fm_voice_allocator_keyon_writer_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  fm_voice_write_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .backlog   (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic in_item_t make_event(input int note, input int vel, input int inst,
                                          input bit carrier, input bit ron,
                                          input int rtype, input bit am, input bit vib);
    in_item_t ev;
    ev.note            = 7'(note);
    ev.velocity        = 7'(vel);
    ev.instrument_id   = 8'(inst);
    ev.carrier_enabled = carrier;
    ev.rhythm_on       = ron;
    ev.rhythm_type     = 4'(rtype);
    ev.am_depth        = am;
    ev.vib_depth       = vib;
    return ev;
  endfunction

  function automatic in_item_t random_event();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(in_item_t)-1:0];
  endfunction

  // valid stays up from one item to the next unless a gap is drawn
  task automatic send_event(input in_item_t ev);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every owed result has left
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  // setup then access phase
  task automatic set_perc_enable(input bit on);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * int'(CFG_RHYTHM_ENABLE));
    pwdata  <= 32'(on);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int        gap_by_phase   [3];
    int        stall_by_phase [3];
    int        pick;
    int        slot;
    int        drum_kinds     [7];
    in_item_t  ev;
    logic [14:0] nv;

    gap_by_phase   = '{20, 71, 0};
    stall_by_phase = '{71, 20, 0};
    drum_kinds     = '{6, 7, 8, 9, 10, 0, 15};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct   = gap_by_phase[0];
    recv_stall_pct = stall_by_phase[0];
    set_perc_enable(1'b0);

    // melodic: extremes, fill every voice, drop when full, release and reuse
    send_event(make_event(0, 127, 0, 1, 0, 0, 0, 0));
    send_event(make_event(127, 1, 255, 0, 1, 15, 1, 1));
    for (int i = 0; i < NUM_CHANNELS - 2; i++) begin
      send_event(make_event(60 + i, 64, 8'hA5, 1, 0, i, 1'(i % 2), 1));
      held_q.push_back({8'hA5, 7'(60 + i)});
    end
    send_event(make_event(61, 100, 3, 1, 0, 0, 0, 0));        // no free voice
    send_event(make_event(127, 0, 254, 0, 0, 0, 0, 0));       // wrong instrument
    send_event(make_event(127, 0, 255, 0, 0, 0, 0, 0));       // releases voice 1
    send_event(make_event(69, 127, 77, 0, 0, 0, 0, 0));       // reuses voice 1
    held_q.push_back({8'd77, 7'd69});

    // rhythm mode: each drum kind, a non-drum kind, key-off, melodic passthrough
    settle();
    set_perc_enable(1'b1);
    foreach (drum_kinds[k])
      send_event(make_event(20 * k + 7, 1 + 18 * k, 200 + k, 1'(k % 2), 1,
                            drum_kinds[k], 1'(k % 2), 1'((k / 2) % 2)));
    send_event(make_event(90, 0, 13, 1, 1, 6, 1, 1));         // rhythm key-off
    send_event(make_event(0, 0, 0, 0, 0, 8, 1, 0));           // frees voice 0

    // random traffic, rhythm mode toggled between chunks
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct   = gap_by_phase[phase];
      recv_stall_pct = stall_by_phase[phase];
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
        settle();
        set_perc_enable(chunk % 2 == 1);
        for (int n = 0; n < CHUNK_ITEMS; n++) begin
          ev   = random_event();
          pick = $urandom_range(99);
          if (pick < (held_q.size() < NUM_CHANNELS ? 55 : 15)) begin
            ev.velocity = 7'($urandom_range(1, 127));
            held_q.push_back({ev.instrument_id, ev.note});
          end else if (pick < 88 && held_q.size() != 0) begin
            slot = $urandom_range(held_q.size() - 1);
            nv   = held_q[slot];
            held_q.delete(slot);
            ev.velocity      = 7'd0;
            ev.note          = nv[6:0];
            ev.instrument_id = nv[14:7];
          end
          send_event(ev);
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && backlog == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
